@@ sv/assert_macros.svh @@
// Assertion macros used by the tangent unit datapath.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define MTAO_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define MTAO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/mtao_pkg.sv @@
// Package for the mesh tangent unit: constants, codes and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package mtao_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int VIDX_W       = 12;
  localparam int CNT_W        = 13;
  localparam int IN_TDATA_W   = 248;
  localparam int OUT_TDATA_W  = 64;

  localparam logic [1:0] FN_LOAD = 2'd0;
  localparam logic [1:0] FN_TRI  = 2'd1;
  localparam logic [1:0] FN_QRY  = 2'd2;
  localparam logic [1:0] FN_CLR  = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_NOTLD = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [1:0] A_CNT = 2'd0;
  localparam logic [1:0] A_I1  = 2'd1;
  localparam logic [1:0] A_I2  = 2'd2;
  localparam logic [1:0] A_I3  = 2'd3;

  localparam logic [1:0] CV_NONE = 2'd0;
  localparam logic [1:0] CV_V1   = 2'd1;
  localparam logic [1:0] CV_V2   = 2'd2;
  localparam logic [1:0] CV_V3   = 2'd3;

  localparam logic [2:0] MS_DET_A = 3'd0;
  localparam logic [2:0] MS_DET_B = 3'd1;
  localparam logic [2:0] MS_NUM_A = 3'd2;
  localparam logic [2:0] MS_NUM_B = 3'd3;
  localparam logic [2:0] MS_SQ    = 3'd4;

  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  localparam logic [1:0] DOP_NONE = 2'd0;
  localparam logic [1:0] DOP_LOAD = 2'd1;
  localparam logic [1:0] DOP_ADD  = 2'd2;

  localparam logic [1:0] TH_NONE = 2'd0;
  localparam logic [1:0] TH_X    = 2'd1;
  localparam logic [1:0] TH_Z    = 2'd2;

  localparam logic signed [15:0] POLE_LIM = 16'sd16368;

  typedef struct packed {
    logic       cap_in;
    logic       res_clr;
    logic       stat_set;
    logic [1:0] stat;
    logic       idx_cap;
    logic       idx_from_cnt;
    logic [1:0] addr_sel;
    logic       ld_we;
    logic       cnt_inc;
    logic       cnt_clr;
    logic [1:0] cap_v;
    logic [2:0] mul_sel;
    logic [1:0] acc_op;
    logic [1:0] comp;
    logic [1:0] comp2;
    logic       det_cap;
    logic       div_start;
    logic       div_norm;
    logic       div_step;
    logic       sd_cap;
    logic       sum_we;
    logic       q_cap;
    logic       g_use_d;
    logic [1:0] d_op;
    logic       d_sat;
    logic       tmp_wr;
    logic [1:0] tmp_hlp;
    logic       mag_cap;
    logic       mag_shr;
    logic       sq_init;
    logic       sq_step;
    logic       tan_wr;
    logic       out_write;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       full;
    logic       bad_tri;
    logic       bad_q;
    logic       det_zero;
    logic       pole;
    logic       pole_use_x;
    logic       tmp_zero;
    logic       zero_use_x;
    logic       mag_big;
    logic       len_zero;
    logic       out_busy;
  } sts_t;

endpackage

@@ sv/mesh_tangent_accumulate_orthogonalize_unit.sv @@
// Top level of the per-vertex tangent unit: sequencer plus datapath.
// Uses mtao_pkg, mtao_ctrl, mtao_dpath.
//
//  channel | direction | tdata                                  | tuser
//  in_     | slave     | pos xyz, tex uv, norm xyz, idx 1..3    | func
//  out_    | master    | vertex index, tangent xyz              | status
//
// One beat in flight. Three divider passes dominate a triangle or a query
// (per s-direction component or per tangent component), plus a 32-step
// square root and up to 19 normalizing shifts in a query. A new beat is taken
// once the result sits in the output register, even while it still waits.
// Reset clears the vertex count; store contents stay unknown until loaded.
`timescale 1ns / 1ps
module mesh_tangent_accumulate_orthogonalize_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
  // first_index, second_index, third_index, zero pad
  input  logic [mtao_pkg::IN_TDATA_W-1:0]    in_tdata,
  // func
  input  logic [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // vertex index, tangent_x, tangent_y, tangent_z, zero pad
  output logic [mtao_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // status
  output logic [1:0]                         out_tuser
);

  mtao_pkg::cmd_t cmd;
  mtao_pkg::sts_t sts;

  mtao_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mtao_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ sv/mtao_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module mtao_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ sv/mtao_dpath.sv @@
// Datapath of the tangent unit: vertex stores, multipliers, divider,
// square root and result register. Uses mtao_pkg, mtao_ram, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mtao_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mtao_pkg::cmd_t                     cmd,
  output mtao_pkg::sts_t                     sts,
  input  logic [mtao_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [1:0]                         in_tuser,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [mtao_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [1:0]                         out_tuser
);

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v > 33'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -33'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
    if (v > 52'sh7FFFFFFFFFFF) return 48'sh7FFFFFFFFFFF;
    if (v < -52'sh800000000000) return 48'sh800000000000;
    return v[47:0];
  endfunction

  // captured input beat
  logic [1:0]                    func_r;
  logic [95:0]                   pin_r;
  logic [63:0]                   tin_r;
  logic [47:0]                   nin_r;
  logic [mtao_pkg::VIDX_W-1:0]   i1_r, i2_r, i3_r;
  logic [mtao_pkg::CNT_W-1:0]    count_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      pin_r  <= in_tdata[95:0];
      tin_r  <= in_tdata[159:96];
      nin_r  <= in_tdata[207:160];
      i1_r   <= in_tdata[219:208];
      i2_r   <= in_tdata[231:220];
      i3_r   <= in_tdata[243:232];
      func_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.cnt_clr) begin
      count_r <= '0;
    end else if (cmd.cnt_inc) begin
      count_r <= count_r + 1'b1;
    end
  end

  // stores
  logic [mtao_pkg::VIDX_W-1:0] addr;
  logic [95:0]  pos_rd;
  logic [63:0]  tex_rd;
  logic [47:0]  nrm_rd;
  logic [143:0] sum_rd, sum_wd;

  always_comb begin
    unique case (cmd.addr_sel)
      mtao_pkg::A_CNT: addr = count_r[mtao_pkg::VIDX_W-1:0];
      mtao_pkg::A_I1:  addr = i1_r;
      mtao_pkg::A_I2:  addr = i2_r;
      default:         addr = i3_r;
    endcase
  end

  mtao_ram #(.WIDTH(96), .DEPTH(mtao_pkg::MAX_VERTICES)) u_pos (
    .clk(clk), .we(cmd.ld_we), .addr(addr), .wdata(pin_r), .rdata(pos_rd));
  mtao_ram #(.WIDTH(64), .DEPTH(mtao_pkg::MAX_VERTICES)) u_tex (
    .clk(clk), .we(cmd.ld_we), .addr(addr), .wdata(tin_r), .rdata(tex_rd));
  mtao_ram #(.WIDTH(48), .DEPTH(mtao_pkg::MAX_VERTICES)) u_nrm (
    .clk(clk), .we(cmd.ld_we), .addr(addr), .wdata(nin_r), .rdata(nrm_rd));
  mtao_ram #(.WIDTH(144), .DEPTH(mtao_pkg::MAX_VERTICES)) u_sum (
    .clk(clk), .we(cmd.ld_we | cmd.sum_we), .addr(addr), .wdata(sum_wd),
    .rdata(sum_rd));

  // triangle deltas
  logic [95:0] p1_r;
  logic [63:0] tx1_r;
  logic signed [31:0] e1_r [3];
  logic signed [31:0] e2_r [3];
  logic signed [31:0] s1_r, t1_r, s2_r, t2_r;
  logic signed [31:0] dpos [3];
  logic signed [31:0] du, dv;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dpos[c] = sat32($signed({pos_rd[32*c+31], pos_rd[32*c+:32]})
                    - $signed({p1_r[32*c+31], p1_r[32*c+:32]}));
    end
    du = sat32($signed({tex_rd[31], tex_rd[31:0]}) - $signed({tx1_r[31], tx1_r[31:0]}));
    dv = sat32($signed({tex_rd[63], tex_rd[63:32]}) - $signed({tx1_r[63], tx1_r[63:32]}));
  end

  always_ff @(posedge clk) begin
    unique case (cmd.cap_v)
      mtao_pkg::CV_V1: begin
        p1_r  <= pos_rd;
        tx1_r <= tex_rd;
      end
      mtao_pkg::CV_V2: begin
        for (int c = 0; c < 3; c++) e1_r[c] <= dpos[c];
        s1_r <= du;
        t1_r <= dv;
      end
      mtao_pkg::CV_V3: begin
        for (int c = 0; c < 3; c++) e2_r[c] <= dpos[c];
        s2_r <= du;
        t2_r <= dv;
      end
      default: ;
    endcase
  end

  // shared 32x32 multiplier and accumulator
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod_r;
  logic signed [65:0] acc_r, det_r;
  logic [48:0] m_r [3];
  logic        tneg_r [3];

  always_comb begin
    unique case (cmd.mul_sel)
      mtao_pkg::MS_DET_A: begin ma = s1_r; mb = t2_r; end
      mtao_pkg::MS_DET_B: begin ma = s2_r; mb = t1_r; end
      mtao_pkg::MS_NUM_A: begin ma = t2_r; mb = e1_r[cmd.comp]; end
      mtao_pkg::MS_NUM_B: begin ma = t1_r; mb = e2_r[cmd.comp]; end
      default: begin
        ma = $signed({2'b00, m_r[cmd.comp][29:0]});
        mb = ma;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    unique case (cmd.acc_op)
      mtao_pkg::ACC_LOAD: acc_r <= 66'(prod_r);
      mtao_pkg::ACC_ADD:  acc_r <= acc_r + 66'(prod_r);
      mtao_pkg::ACC_SUB:  acc_r <= acc_r - 66'(prod_r);
      default: ;
    endcase
    if (cmd.det_cap) det_r <= acc_r;
  end

  logic signed [65:0] acc_neg, det_neg;
  logic [63:0] acc_mag, det_mag;
  assign acc_neg = -acc_r;
  assign det_neg = -det_r;
  assign acc_mag = acc_r[65] ? acc_neg[63:0] : acc_r[63:0];
  assign det_mag = det_r[65] ? det_neg[63:0] : det_r[63:0];

  // square root
  logic [63:0] sx_r, sres_r, sbit_r;
  logic [63:0] s_try;
  logic [31:0] len;
  assign s_try = sres_r + sbit_r;
  assign len   = sres_r[31:0];

  always_ff @(posedge clk) begin
    if (cmd.sq_init) begin
      sx_r   <= acc_r[63:0];
      sres_r <= '0;
      sbit_r <= 64'h4000_0000_0000_0000;
    end else if (cmd.sq_step) begin
      if (sx_r >= s_try) begin
        sx_r   <= sx_r - s_try;
        sres_r <= (sres_r >> 1) + sbit_r;
      end else begin
        sres_r <= sres_r >> 1;
      end
      sbit_r <= sbit_r >> 2;
    end
  end

  // restoring divider, one quotient bit per step
  logic [79:0] dvd_r, quo_r;
  logic [63:0] den_r, rem_r;
  logic        dneg_r;
  logic [64:0] rsh, rdif;
  logic        rge;
  logic [44:0] ndvd;
  assign rsh  = {rem_r, dvd_r[79]};
  assign rdif = rsh - {1'b0, den_r};
  assign rge  = rsh >= {1'b0, den_r};
  assign ndvd = {1'b0, m_r[cmd.comp][29:0], 14'b0} + 45'(len[31:1]);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= '0;
      if (cmd.div_norm) begin
        dvd_r  <= 80'(ndvd);
        den_r  <= 64'(len);
        dneg_r <= tneg_r[cmd.comp];
      end else begin
        dvd_r  <= {acc_mag, 16'b0};
        den_r  <= det_mag;
        dneg_r <= acc_r[65] ^ det_r[65];
      end
    end else if (cmd.div_step) begin
      rem_r <= rge ? rdif[63:0] : rsh[63:0];
      quo_r <= {quo_r[78:0], rge};
      dvd_r <= {dvd_r[78:0], 1'b0};
    end
  end

  // s-direction and saturating sums
  logic signed [31:0] sd_r [3];
  logic signed [31:0] sdv;
  logic               qbig;
  logic signed [47:0] snew [3];
  assign qbig = |quo_r[79:31];

  always_comb begin
    if (!dneg_r) begin
      sdv = qbig ? 32'sh7FFFFFFF : $signed(quo_r[31:0]);
    end else begin
      sdv = qbig ? 32'sh80000000 : $signed(-quo_r[31:0]);
    end
    for (int c = 0; c < 3; c++) begin
      snew[c] = sat48(52'($signed(sum_rd[48*c+:48])) + 52'(sd_r[c]));
    end
    sum_wd = cmd.ld_we ? '0 : {snew[2], snew[1], snew[0]};
  end

  always_ff @(posedge clk) begin
    if (cmd.sd_cap) sd_r[cmd.comp] <= sdv;
  end

  // query: Gram-Schmidt against the normal
  logic signed [15:0] n_r [3];
  logic signed [47:0] t_r [3];
  logic signed [47:0] gb, d_r;
  logic signed [63:0] gp_r, gsh;
  logic signed [51:0] dacc_r;
  logic signed [48:0] tmp_r [3];
  logic signed [64:0] tdif;

  assign gb   = cmd.g_use_d ? d_r : t_r[cmd.comp];
  assign gsh  = gp_r >>> 14;
  assign tdif = 65'(t_r[cmd.comp2]) - 65'(gsh);

  always_ff @(posedge clk) begin
    if (cmd.q_cap) begin
      for (int c = 0; c < 3; c++) begin
        n_r[c] <= nrm_rd[16*c+:16];
        t_r[c] <= sum_rd[48*c+:48];
      end
    end
    gp_r <= n_r[cmd.comp] * gb;
    unique case (cmd.d_op)
      mtao_pkg::DOP_LOAD: dacc_r <= 52'(gsh);
      mtao_pkg::DOP_ADD:  dacc_r <= dacc_r + 52'(gsh);
      default: ;
    endcase
    if (cmd.d_sat) d_r <= sat48(dacc_r);
    if (cmd.tmp_wr) tmp_r[cmd.comp2] <= tdif[48:0];
    unique case (cmd.tmp_hlp)
      mtao_pkg::TH_X: begin
        tmp_r[0] <= '0;
        tmp_r[1] <= -49'(n_r[2]);
        tmp_r[2] <= 49'(n_r[1]);
      end
      mtao_pkg::TH_Z: begin
        tmp_r[0] <= -49'(n_r[1]);
        tmp_r[1] <= 49'(n_r[0]);
        tmp_r[2] <= '0;
      end
      default: ;
    endcase
    for (int c = 0; c < 3; c++) begin
      if (cmd.mag_cap) begin
        m_r[c]    <= tmp_r[c][48] ? 49'(-tmp_r[c]) : 49'(tmp_r[c]);
        tneg_r[c] <= tmp_r[c][48];
      end else if (cmd.mag_shr) begin
        m_r[c] <= m_r[c] >> 1;
      end
    end
  end

  // result and output registers
  logic [1:0]                  res_stat_r, out_stat_r;
  logic [mtao_pkg::VIDX_W-1:0] res_idx_r, out_idx_r;
  logic [15:0]                 res_tan_r [3];
  logic [15:0]                 out_tan_r [3];
  logic                        out_valid_r;
  logic [15:0]                 qneg;
  assign qneg = -quo_r[15:0];

  always_ff @(posedge clk) begin
    if (cmd.stat_set) begin
      res_stat_r <= cmd.stat;
    end else if (cmd.res_clr) begin
      res_stat_r <= mtao_pkg::ST_DONE;
    end
    if (cmd.idx_cap) begin
      res_idx_r <= cmd.idx_from_cnt ? count_r[mtao_pkg::VIDX_W-1:0] : i1_r;
    end else if (cmd.res_clr) begin
      res_idx_r <= '0;
    end
    if (cmd.res_clr) begin
      for (int c = 0; c < 3; c++) res_tan_r[c] <= '0;
    end else if (cmd.tan_wr) begin
      res_tan_r[cmd.comp] <= dneg_r ? qneg : quo_r[15:0];
    end
    if (cmd.out_write) begin
      out_stat_r <= res_stat_r;
      out_idx_r  <= res_idx_r;
      for (int c = 0; c < 3; c++) out_tan_r[c] <= res_tan_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_write) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {4'b0, out_tan_r[2], out_tan_r[1], out_tan_r[0], out_idx_r};

  // status
  always_comb begin
    sts.func       = func_r;
    sts.full       = count_r >= mtao_pkg::CNT_W'(mtao_pkg::MAX_VERTICES);
    sts.bad_q      = {1'b0, i1_r} >= count_r;
    sts.bad_tri    = ({1'b0, i1_r} >= count_r) || ({1'b0, i2_r} >= count_r)
                  || ({1'b0, i3_r} >= count_r);
    sts.det_zero   = acc_r == '0;
    sts.pole       = (n_r[1] >= mtao_pkg::POLE_LIM) || (n_r[1] <= -mtao_pkg::POLE_LIM);
    sts.pole_use_x = n_r[1] < mtao_pkg::POLE_LIM;
    sts.zero_use_x = !(n_r[2] < mtao_pkg::POLE_LIM);
    sts.tmp_zero   = (tmp_r[0] == '0) && (tmp_r[1] == '0) && (tmp_r[2] == '0);
    sts.mag_big    = (|m_r[0][48:30]) || (|m_r[1][48:30]) || (|m_r[2][48:30]);
    sts.len_zero   = sres_r == '0;
    sts.out_busy   = out_valid_r && !out_tready;
  end

  `MTAO_ASSERT(a_count_bound, count_r <= mtao_pkg::CNT_W'(mtao_pkg::MAX_VERTICES))
  `MTAO_ASSERT(a_no_overwrite, !(cmd.out_write && out_valid_r && !out_tready))
  `MTAO_ASSERT_NEXT(a_load_counts, cmd.ld_we, count_r == $past(count_r) + 1'b1)

endmodule

@@ sv/mtao_ctrl.sv @@
// Sequencer of the tangent unit: steps the datapath through load,
// triangle, query and clear. Uses mtao_pkg.
`timescale 1ns / 1ps
module mtao_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  mtao_pkg::sts_t sts,
  output mtao_pkg::cmd_t cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_TRD   = 5'd2;
  localparam logic [4:0] S_TDET  = 5'd3;
  localparam logic [4:0] S_TDCHK = 5'd4;
  localparam logic [4:0] S_TNUM  = 5'd5;
  localparam logic [4:0] S_TDIV  = 5'd6;
  localparam logic [4:0] S_TSD   = 5'd7;
  localparam logic [4:0] S_TACC  = 5'd8;
  localparam logic [4:0] S_QCAP  = 5'd9;
  localparam logic [4:0] S_QCHK  = 5'd10;
  localparam logic [4:0] S_QD    = 5'd11;
  localparam logic [4:0] S_QT    = 5'd12;
  localparam logic [4:0] S_QZ    = 5'd13;
  localparam logic [4:0] S_NMAG  = 5'd14;
  localparam logic [4:0] S_NSH   = 5'd15;
  localparam logic [4:0] S_NSQ   = 5'd16;
  localparam logic [4:0] S_NSQI  = 5'd17;
  localparam logic [4:0] S_NSQR  = 5'd18;
  localparam logic [4:0] S_NLEN  = 5'd19;
  localparam logic [4:0] S_NDIV  = 5'd20;
  localparam logic [4:0] S_NTAN  = 5'd21;
  localparam logic [4:0] S_FIN   = 5'd22;

  localparam logic [6:0] DIV_LAST = 7'd80;
  localparam logic [6:0] SQ_LAST  = 7'd31;

  logic [4:0] state_r, state_nxt;
  logic [6:0] step_r, step_nxt;
  logic [1:0] comp_r, comp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      comp_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      comp_r  <= comp_nxt;
    end
  end

  assign in_tready = state_r == S_IDLE;

  always_comb begin
    cmd       = '0;
    cmd.comp  = comp_r;
    state_nxt = state_r;
    step_nxt  = step_r + 1'b1;
    comp_nxt  = comp_r;
    unique case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        comp_nxt = '0;
        if (in_tvalid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        cmd.res_clr  = 1'b1;
        cmd.addr_sel = mtao_pkg::A_I1;
        step_nxt     = '0;
        unique case (sts.func)
          mtao_pkg::FN_LOAD: begin
            state_nxt = S_FIN;
            if (sts.full) begin
              cmd.stat_set = 1'b1;
              cmd.stat     = mtao_pkg::ST_FULL;
            end else begin
              cmd.addr_sel     = mtao_pkg::A_CNT;
              cmd.ld_we        = 1'b1;
              cmd.idx_cap      = 1'b1;
              cmd.idx_from_cnt = 1'b1;
              cmd.cnt_inc      = 1'b1;
            end
          end
          mtao_pkg::FN_TRI: begin
            if (sts.bad_tri) begin
              cmd.stat_set = 1'b1;
              cmd.stat     = mtao_pkg::ST_NOTLD;
              state_nxt    = S_FIN;
            end else begin
              state_nxt = S_TRD;
            end
          end
          mtao_pkg::FN_QRY: begin
            cmd.idx_cap = 1'b1;
            if (sts.bad_q) begin
              cmd.stat_set = 1'b1;
              cmd.stat     = mtao_pkg::ST_NOTLD;
              state_nxt    = S_FIN;
            end else begin
              state_nxt = S_QCAP;
            end
          end
          default: begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = S_FIN;
          end
        endcase
      end
      S_TRD: begin
        cmd.cap_v    = 2'(step_r + 1'b1);
        cmd.addr_sel = 2'(step_r + 2'd2);
        if (step_r == 7'd2) begin
          step_nxt  = '0;
          state_nxt = S_TDET;
        end
      end
      S_TDET: begin
        cmd.mul_sel = (step_r == 7'd0) ? mtao_pkg::MS_DET_A : mtao_pkg::MS_DET_B;
        priority case (step_r)
          7'd1:    cmd.acc_op = mtao_pkg::ACC_LOAD;
          7'd2:    cmd.acc_op = mtao_pkg::ACC_SUB;
          default: cmd.acc_op = mtao_pkg::ACC_NONE;
        endcase
        if (step_r == 7'd2) state_nxt = S_TDCHK;
      end
      S_TDCHK: begin
        cmd.det_cap = 1'b1;
        step_nxt    = '0;
        comp_nxt    = '0;
        if (sts.det_zero) begin
          cmd.stat_set = 1'b1;
          cmd.stat     = mtao_pkg::ST_DEGEN;
          state_nxt    = S_FIN;
        end else begin
          state_nxt = S_TNUM;
        end
      end
      S_TNUM: begin
        cmd.mul_sel = (step_r == 7'd0) ? mtao_pkg::MS_NUM_A : mtao_pkg::MS_NUM_B;
        priority case (step_r)
          7'd1:    cmd.acc_op = mtao_pkg::ACC_LOAD;
          7'd2:    cmd.acc_op = mtao_pkg::ACC_SUB;
          default: cmd.acc_op = mtao_pkg::ACC_NONE;
        endcase
        if (step_r == 7'd2) begin
          step_nxt  = '0;
          state_nxt = S_TDIV;
        end
      end
      S_TDIV: begin
        cmd.div_start = step_r == 7'd0;
        cmd.div_step  = step_r != 7'd0;
        if (step_r == DIV_LAST) state_nxt = S_TSD;
      end
      S_TSD: begin
        cmd.sd_cap = 1'b1;
        step_nxt   = '0;
        if (comp_r == 2'd2) begin
          comp_nxt  = '0;
          state_nxt = S_TACC;
        end else begin
          comp_nxt  = comp_r + 1'b1;
          state_nxt = S_TNUM;
        end
      end
      S_TACC: begin
        cmd.addr_sel = comp_r + 1'b1;
        if (step_r == 7'd1) begin
          cmd.sum_we = 1'b1;
          step_nxt   = '0;
          if (comp_r == 2'd2) begin
            state_nxt = S_FIN;
          end else begin
            comp_nxt = comp_r + 1'b1;
          end
        end
      end
      S_QCAP: begin
        cmd.q_cap = 1'b1;
        state_nxt = S_QCHK;
      end
      S_QCHK: begin
        step_nxt = '0;
        if (sts.pole) begin
          cmd.tmp_hlp = sts.pole_use_x ? mtao_pkg::TH_X : mtao_pkg::TH_Z;
          state_nxt   = S_NMAG;
        end else begin
          state_nxt = S_QD;
        end
      end
      S_QD: begin
        cmd.comp = step_r[1:0];
        priority case (step_r)
          7'd1:       cmd.d_op = mtao_pkg::DOP_LOAD;
          7'd2, 7'd3: cmd.d_op = mtao_pkg::DOP_ADD;
          default:    cmd.d_op = mtao_pkg::DOP_NONE;
        endcase
        if (step_r == 7'd4) begin
          cmd.d_sat = 1'b1;
          step_nxt  = '0;
          state_nxt = S_QT;
        end
      end
      S_QT: begin
        cmd.comp    = step_r[1:0];
        cmd.g_use_d = 1'b1;
        cmd.comp2   = 2'(step_r - 1'b1);
        cmd.tmp_wr  = step_r != 7'd0;
        if (step_r == 7'd3) state_nxt = S_QZ;
      end
      S_QZ: begin
        if (sts.tmp_zero) begin
          cmd.tmp_hlp = sts.zero_use_x ? mtao_pkg::TH_X : mtao_pkg::TH_Z;
        end
        state_nxt = S_NMAG;
      end
      S_NMAG: begin
        cmd.mag_cap = 1'b1;
        state_nxt   = S_NSH;
      end
      S_NSH: begin
        step_nxt = '0;
        if (sts.mag_big) begin
          cmd.mag_shr = 1'b1;
        end else begin
          state_nxt = S_NSQ;
        end
      end
      S_NSQ: begin
        cmd.comp    = step_r[1:0];
        cmd.mul_sel = mtao_pkg::MS_SQ;
        priority case (step_r)
          7'd1:       cmd.acc_op = mtao_pkg::ACC_LOAD;
          7'd2, 7'd3: cmd.acc_op = mtao_pkg::ACC_ADD;
          default:    cmd.acc_op = mtao_pkg::ACC_NONE;
        endcase
        if (step_r == 7'd3) state_nxt = S_NSQI;
      end
      S_NSQI: begin
        cmd.sq_init = 1'b1;
        step_nxt    = '0;
        state_nxt   = S_NSQR;
      end
      S_NSQR: begin
        cmd.sq_step = 1'b1;
        if (step_r == SQ_LAST) state_nxt = S_NLEN;
      end
      S_NLEN: begin
        step_nxt  = '0;
        comp_nxt  = '0;
        state_nxt = sts.len_zero ? S_FIN : S_NDIV;
      end
      S_NDIV: begin
        cmd.div_norm  = 1'b1;
        cmd.div_start = step_r == 7'd0;
        cmd.div_step  = step_r != 7'd0;
        if (step_r == DIV_LAST) state_nxt = S_NTAN;
      end
      S_NTAN: begin
        cmd.tan_wr = 1'b1;
        step_nxt   = '0;
        if (comp_r == 2'd2) begin
          state_nxt = S_FIN;
        end else begin
          comp_nxt  = comp_r + 1'b1;
          state_nxt = S_NDIV;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_write = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
